// ===== rtl/core/crfhm_pkg.sv =====
package crfhm_pkg;

  localparam int unsigned CoordW = 12;
  localparam int unsigned SizeW  = 13;
  localparam int unsigned CalcW  = 14;
  localparam int unsigned RegW   = 10;
  localparam int unsigned OutIdW = 8;

  typedef enum logic [1:0] {
    OpFill   = 2'd0,
    OpClear  = 2'd1,
    OpLookup = 2'd2
  } op_e;

  typedef enum logic {
    RegGridWidth  = 1'b0,
    RegGridHeight = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    StIdle,
    StSweep,
    StFill,
    StLook
  } state_e;

  typedef struct packed {
    logic              empty;
    logic              hit;
    logic [CoordW-1:0] x0;
    logic [CoordW-1:0] x_last;
    logic [CoordW-1:0] y0;
    logic [CoordW-1:0] y_last;
  } clip_t;

endpackage

// ===== rtl/core/crfhm_if.sv =====
interface crfhm_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic [7:0]         owner_id;
  logic signed [11:0] pos_x;
  logic signed [11:0] pos_y;
  logic [11:0]        rect_width;
  logic [11:0]        rect_height;

  modport source (
    output valid, operation, owner_id, pos_x, pos_y, rect_width, rect_height,
    input  ready
  );
  modport sink (
    input  valid, operation, owner_id, pos_x, pos_y, rect_width, rect_height,
    output ready
  );
endinterface

interface crfhm_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] found_id;

  modport source (output valid, found_id, input ready);
  modport sink (input valid, found_id, output ready);
endinterface

// ===== rtl/core/clipped_rect_fill_hit_map_core.sv =====
// A lookup reads the cell memory into a register at its transfer; the result is then loaded
// into the output register, and the lookup waits while an earlier result is still held.
// A fill writes one cell a cycle over the clipped rectangle, row by row, through the single
// write port of the cell memory; an empty rectangle takes the transfer only.
// A clear sweeps one cell a cycle over the whole memory, taking no item until it ends; the depth is
// 2**(clog2(MAX_WIDTH) + clog2(MAX_HEIGHT)) cells, 262144 at the defaults.
// Reset zeroes the counter, output valid and grid size registers and starts that sweep.
module clipped_rect_fill_hit_map_core #(
  parameter int unsigned MAX_WIDTH  = 512,
  parameter int unsigned MAX_HEIGHT = 512,
  parameter int unsigned ID_BITS    = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic                       cfg_idx_i,
  input  logic [crfhm_pkg::RegW-1:0] cfg_data_i,
  crfhm_in_if.sink                   in_s,
  crfhm_out_if.source                out_s
);

  localparam int unsigned CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned AW    = CW + RW;
  localparam int unsigned Depth = 2 ** AW;
  localparam logic [crfhm_pkg::SizeW-1:0] MaxW = crfhm_pkg::SizeW'(MAX_WIDTH);
  localparam logic [crfhm_pkg::SizeW-1:0] MaxH = crfhm_pkg::SizeW'(MAX_HEIGHT);

  crfhm_pkg::state_e state_q, state_d;

  logic [crfhm_pkg::RegW-1:0]  gw_q, gh_q;
  logic [crfhm_pkg::SizeW-1:0] act_w, act_h;
  crfhm_pkg::clip_t            clip;

  logic [AW-1:0]      cnt_q, cnt_d;
  logic [CW-1:0]      col_q, col_d, x0_q, x0_d, xl_q, xl_d;
  logic [RW-1:0]      row_q, row_d, yl_q, yl_d;
  logic [ID_BITS-1:0] id_q, id_d;
  logic               hit_q, hit_d;

  logic               out_valid_q, out_valid_d;
  logic [7:0]         found_q, found_d;

  logic [ID_BITS-1:0] mem [Depth];
  logic               we, re;
  logic [AW-1:0]      waddr, raddr;
  logic [ID_BITS-1:0] wdata, rd_q;

  logic in_xfer, out_xfer, load_out;

  assign act_w = ({3'b000, gw_q} > MaxW) ? MaxW : {3'b000, gw_q};
  assign act_h = ({3'b000, gh_q} > MaxH) ? MaxH : {3'b000, gh_q};

  crfhm_clip u_clip (
    .pos_x_i  (in_s.pos_x),
    .pos_y_i  (in_s.pos_y),
    .rect_w_i (in_s.rect_width),
    .rect_h_i (in_s.rect_height),
    .act_w_i  (act_w),
    .act_h_i  (act_h),
    .clip_o   (clip)
  );

  assign in_s.ready   = (state_q == crfhm_pkg::StIdle);
  assign in_xfer      = in_s.valid && in_s.ready;
  assign out_s.valid  = out_valid_q;
  assign out_s.found_id = found_q;
  assign out_xfer     = out_valid_q && out_s.ready;
  assign load_out     = (state_q == crfhm_pkg::StLook) && (!out_valid_q || out_s.ready);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      crfhm_pkg::StIdle: begin
        if (in_xfer) begin
          case (in_s.operation)
            crfhm_pkg::OpFill:   state_d = clip.empty ? crfhm_pkg::StIdle : crfhm_pkg::StFill;
            crfhm_pkg::OpClear:  state_d = crfhm_pkg::StSweep;
            crfhm_pkg::OpLookup: state_d = crfhm_pkg::StLook;
            default:             state_d = crfhm_pkg::StIdle;
          endcase
        end
      end
      crfhm_pkg::StSweep: begin
        if (&cnt_q) state_d = crfhm_pkg::StIdle;
      end
      crfhm_pkg::StFill: begin
        if ((col_q == xl_q) && (row_q == yl_q)) state_d = crfhm_pkg::StIdle;
      end
      crfhm_pkg::StLook: begin
        if (load_out) state_d = crfhm_pkg::StIdle;
      end
      default: state_d = crfhm_pkg::StIdle;
    endcase
  end

  always_comb begin
    cnt_d       = cnt_q;
    col_d       = col_q;
    row_d       = row_q;
    x0_d        = x0_q;
    xl_d        = xl_q;
    yl_d        = yl_q;
    id_d        = id_q;
    hit_d       = hit_q;
    out_valid_d = out_valid_q;
    found_d     = found_q;
    we          = 1'b0;
    waddr       = {row_q, col_q};
    wdata       = id_q;
    re          = 1'b0;
    raddr       = {in_s.pos_y[RW-1:0], in_s.pos_x[CW-1:0]};

    if (out_xfer) out_valid_d = 1'b0;

    unique case (state_q)
      crfhm_pkg::StIdle: begin
        if (in_xfer) begin
          cnt_d = '0;
          col_d = clip.x0[CW-1:0];
          row_d = clip.y0[RW-1:0];
          x0_d  = clip.x0[CW-1:0];
          xl_d  = clip.x_last[CW-1:0];
          yl_d  = clip.y_last[RW-1:0];
          id_d  = ID_BITS'(in_s.owner_id);
          hit_d = clip.hit;
          re    = (in_s.operation == crfhm_pkg::OpLookup);
        end
      end
      crfhm_pkg::StSweep: begin
        we    = 1'b1;
        waddr = cnt_q;
        wdata = '0;
        cnt_d = cnt_q + AW'(1);
      end
      crfhm_pkg::StFill: begin
        we = 1'b1;
        if (col_q == xl_q) begin
          col_d = x0_q;
          row_d = row_q + RW'(1);
        end else begin
          col_d = col_q + CW'(1);
        end
      end
      crfhm_pkg::StLook: begin
        if (load_out) begin
          out_valid_d = 1'b1;
          found_d     = hit_q ? 8'(rd_q) : 8'd0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= crfhm_pkg::StSweep;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      gw_q        <= '0;
      gh_q        <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          crfhm_pkg::RegGridWidth:  gw_q <= cfg_data_i;
          crfhm_pkg::RegGridHeight: gh_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    col_q   <= col_d;
    row_q   <= row_d;
    x0_q    <= x0_d;
    xl_q    <= xl_d;
    yl_q    <= yl_d;
    id_q    <= id_d;
    hit_q   <= hit_d;
    found_q <= found_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk_i) begin
    if (re) rd_q <= mem[raddr];
  end

  a_out_from_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == crfhm_pkg::StLook))
    else $error("result appeared without a lookup");

  a_fill_in_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == crfhm_pkg::StFill) |->
      ((crfhm_pkg::SizeW'(col_q) < act_w) && (crfhm_pkg::SizeW'(row_q) < act_h)))
    else $error("fill write outside the active grid");

  a_fill_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == crfhm_pkg::StFill) |-> ((col_q >= x0_q) && (col_q <= xl_q) && (row_q <= yl_q)))
    else $error("fill position left the clipped rectangle");

  a_held_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_s.ready) |=> (out_valid_q && $stable(found_q)))
    else $error("waiting result was lost or changed");

endmodule

// ===== rtl/core/crfhm_clip.sv =====
module crfhm_clip (
  input  logic signed [11:0]                  pos_x_i,
  input  logic signed [11:0]                  pos_y_i,
  input  logic [11:0]                         rect_w_i,
  input  logic [11:0]                         rect_h_i,
  input  logic [crfhm_pkg::SizeW-1:0]         act_w_i,
  input  logic [crfhm_pkg::SizeW-1:0]         act_h_i,
  output crfhm_pkg::clip_t                    clip_o
);

  logic signed [crfhm_pkg::CalcW-1:0] xs, ys, aw, ah;
  logic signed [crfhm_pkg::CalcW-1:0] x0, y0, x1, y1, x1c, y1c, xl, yl;

  always_comb begin
    xs  = crfhm_pkg::CalcW'(pos_x_i);
    ys  = crfhm_pkg::CalcW'(pos_y_i);
    aw  = $signed({1'b0, act_w_i});
    ah  = $signed({1'b0, act_h_i});
    x0  = (xs < 0) ? '0 : xs;
    y0  = (ys < 0) ? '0 : ys;
    x1  = xs + $signed({2'b00, rect_w_i});
    y1  = ys + $signed({2'b00, rect_h_i});
    x1c = (x1 > aw) ? aw : x1;
    y1c = (y1 > ah) ? ah : y1;
    xl  = x1c - crfhm_pkg::CalcW'(1);
    yl  = y1c - crfhm_pkg::CalcW'(1);

    clip_o.empty  = (x0 >= x1c) || (y0 >= y1c);
    clip_o.hit    = (xs >= 0) && (ys >= 0) && (xs < aw) && (ys < ah);
    clip_o.x0     = x0[crfhm_pkg::CoordW-1:0];
    clip_o.y0     = y0[crfhm_pkg::CoordW-1:0];
    clip_o.x_last = xl[crfhm_pkg::CoordW-1:0];
    clip_o.y_last = yl[crfhm_pkg::CoordW-1:0];
  end

endmodule
